[src/rahd_pkg.sv]
package rahd_pkg;

    // Result status codes.
    localparam logic [2:0] ST_UPDATED          = 3'd0;
    localparam logic [2:0] ST_HANDOVER         = 3'd1;
    localparam logic [2:0] ST_NO_HANDOVER      = 3'd2;
    localparam logic [2:0] ST_UNKNOWN_TERMINAL = 3'd3;
    localparam logic [2:0] ST_EMPTY_A4         = 3'd4;
    localparam logic [2:0] ST_UNKNOWN_ID       = 3'd5;
    localparam logic [2:0] ST_FULL             = 3'd6;
    localparam logic [2:0] ST_INVALID_A2       = 3'd7;

    // Configuration register indexes.
    localparam logic [1:0] CFG_A2_ID     = 2'd0;
    localparam logic [1:0] CFG_A4_ID     = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD = 2'd2;
    localparam logic [1:0] CFG_OFFSET    = 2'd3;

    // Field widths.
    localparam int ID_W   = 8;
    localparam int RNTI_W = 16;
    localparam int CELL_W = 16;
    localparam int Q_W    = 6;

    // Register reset values.
    localparam logic [ID_W-1:0] A2_ID_RST     = 8'd1;
    localparam logic [ID_W-1:0] A4_ID_RST     = 8'd2;
    localparam logic [Q_W-1:0]  THRESHOLD_RST = 6'd30;
    localparam logic [Q_W-1:0]  OFFSET_RST    = 6'd1;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_TERM = 4'b0010,
        S_NBR  = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    // Flags of the lookup token that travels along the terminal cells.
    typedef struct packed {
        logic valid;
        logic hit;
        logic free_found;
    } tok_flags_t;

endpackage

[src/rahd_if.sv]
interface rahd_in_if;
    import rahd_pkg::*;
    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   report_id;
    logic [RNTI_W-1:0] terminal;
    logic              neighbour_present;
    logic [CELL_W-1:0] neighbour_cell;
    logic [Q_W-1:0]    quality;

    modport source (output valid, report_id, terminal, neighbour_present,
                    neighbour_cell, quality, input ready);
    modport sink (input valid, report_id, terminal, neighbour_present,
                  neighbour_cell, quality, output ready);
endinterface

interface rahd_out_if;
    import rahd_pkg::*;
    logic              valid;
    logic              ready;
    logic [2:0]        status;
    logic              handover;
    logic [CELL_W-1:0] target_cell;

    modport source (output valid, status, handover, target_cell, input ready);
    modport sink (input valid, status, handover, target_cell, output ready);
endinterface

[src/rahd_term_cell.sv]
module rahd_term_cell
    import rahd_pkg::*;
#(
    parameter int TIW    = 4,
    parameter int NBR    = 8,
    parameter int MY_IDX = 0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [RNTI_W-1:0] key,
    input  tok_flags_t        flags_in,
    input  logic [TIW-1:0]    hit_idx_in,
    input  logic [TIW-1:0]    free_idx_in,
    input  logic [NBR-1:0]    mask_in,
    output tok_flags_t        flags_out,
    output logic [TIW-1:0]    hit_idx_out,
    output logic [TIW-1:0]    free_idx_out,
    output logic [NBR-1:0]    mask_out,
    input  logic              wr_en,
    input  logic [TIW-1:0]    wr_idx,
    input  logic [RNTI_W-1:0] wr_tag,
    input  logic [NBR-1:0]    wr_mask
);

    localparam logic [TIW-1:0] MY = TIW'(MY_IDX);

    logic              valid_reg;
    logic [RNTI_W-1:0] tag_reg;
    logic [NBR-1:0]    mask_reg;
    tok_flags_t        flags_reg;
    logic [TIW-1:0]    hit_idx_reg;
    logic [TIW-1:0]    free_idx_reg;
    logic [NBR-1:0]    tmask_reg;
    logic              match;

    assign match = valid_reg && (tag_reg == key);

    // Stored terminal slot: tag and the valid bits of its neighbour list.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            mask_reg  <= '0;
        end
        else if (wr_en && (wr_idx == MY))
        begin
            valid_reg <= 1'b1;
            mask_reg  <= wr_mask;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_idx == MY))
        begin
            tag_reg <= wr_tag;
        end
    end

    // The token picks up the first match and the first free slot on its way.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg.valid      <= flags_in.valid;
            flags_reg.hit        <= flags_in.hit | match;
            flags_reg.free_found <= flags_in.free_found | !valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg  <= (flags_in.hit || !match) ? hit_idx_in : MY;
        tmask_reg    <= (flags_in.hit || !match) ? mask_in : mask_reg;
        free_idx_reg <= (flags_in.free_found || valid_reg) ? free_idx_in : MY;
    end

    assign flags_out    = flags_reg;
    assign hit_idx_out  = hit_idx_reg;
    assign free_idx_out = free_idx_reg;
    assign mask_out     = tmask_reg;

endmodule

[src/rsrq_a2_a4_handover_decision.sv]
// Channel   Dir  Payload
// in_ch     in   report_id, terminal, neighbour_present, neighbour_cell, quality
// out_ch    out  status, handover, target_cell
// cfg       in   cfg_we, cfg_index, cfg_data (write only)
//
// An item that goes through the neighbour scan first sends the lookup token along the row
// of terminal cells, one cell per cycle, then reads its neighbour list one entry per cycle
// from the neighbour memory, which has one read and one write port. An A2 item for an
// unknown terminal, or an A4 item that finds the terminal table full, ends after the row.
// Other items skip the row and the scan. One item is in work at a time; a finished result
// waits in the output register while the next item is accepted, and only a second result
// stalls the block. Reset clears all terminal slots at once; no clearing pass is needed.
module rsrq_a2_a4_handover_decision
    import rahd_pkg::*;
#(
    parameter int MAX_TERMINALS  = 16,
    parameter int MAX_NEIGHBOURS = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    rahd_in_if.sink       in_ch,
    rahd_out_if.source    out_ch,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [ID_W-1:0] cfg_data
);

    localparam int TIW   = (MAX_TERMINALS > 1) ? $clog2(MAX_TERMINALS) : 1;
    localparam int NIW   = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
    localparam int NCW   = $clog2(MAX_NEIGHBOURS + 1);
    localparam int AW    = TIW + NIW;
    localparam int MW    = CELL_W + Q_W;
    localparam logic [NCW-1:0] NBR_CNT = NCW'(MAX_NEIGHBOURS);
    localparam logic [NIW-1:0] LAST_SLOT = NIW'(MAX_NEIGHBOURS - 1);

    // Configuration registers.
    logic [ID_W-1:0] a2_id_reg;
    logic [ID_W-1:0] a4_id_reg;
    logic [Q_W-1:0]  thr_reg;
    logic [Q_W-1:0]  off_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a2_id_reg <= A2_ID_RST;
            a4_id_reg <= A4_ID_RST;
            thr_reg   <= THRESHOLD_RST;
            off_reg   <= OFFSET_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_A2_ID:     a2_id_reg <= cfg_data;
                CFG_A4_ID:     a4_id_reg <= cfg_data;
                CFG_THRESHOLD: thr_reg   <= cfg_data[Q_W-1:0];
                CFG_OFFSET:    off_reg   <= cfg_data[Q_W-1:0];
                default:       ;
            endcase
        end
    end

    state_t state_reg, state_next;

    logic              accept;
    logic [RNTI_W-1:0] rnti_reg;
    logic [CELL_W-1:0] cell_reg;
    logic [Q_W-1:0]    q_reg;
    logic              is_a2_reg;
    logic              start_reg;
    logic [2:0]        res_status_reg;
    logic [CELL_W-1:0] res_target_reg;

    assign accept      = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);

    // Row of terminal cells; the lookup token enters at cell 0.
    tok_flags_t     flags_chain [0:MAX_TERMINALS];
    logic [TIW-1:0] hidx_chain  [0:MAX_TERMINALS];
    logic [TIW-1:0] fidx_chain  [0:MAX_TERMINALS];
    logic [MAX_NEIGHBOURS-1:0] mask_chain [0:MAX_TERMINALS];

    logic                      twr_en;
    logic [TIW-1:0]            tsel_reg;
    logic [MAX_NEIGHBOURS-1:0] nmask_reg;
    logic [MAX_NEIGHBOURS-1:0] new_mask;

    assign flags_chain[0] = '{valid: start_reg, hit: 1'b0, free_found: 1'b0};
    assign hidx_chain[0]  = '0;
    assign fidx_chain[0]  = '0;
    assign mask_chain[0]  = '0;

    for (genvar k = 0; k < MAX_TERMINALS; k++)
    begin : g_cell
        rahd_term_cell #(
            .TIW    (TIW),
            .NBR    (MAX_NEIGHBOURS),
            .MY_IDX (k)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .key          (rnti_reg),
            .flags_in     (flags_chain[k]),
            .hit_idx_in   (hidx_chain[k]),
            .free_idx_in  (fidx_chain[k]),
            .mask_in      (mask_chain[k]),
            .flags_out    (flags_chain[k+1]),
            .hit_idx_out  (hidx_chain[k+1]),
            .free_idx_out (fidx_chain[k+1]),
            .mask_out     (mask_chain[k+1]),
            .wr_en        (twr_en),
            .wr_idx       (tsel_reg),
            .wr_tag       (rnti_reg),
            .wr_mask      (new_mask)
        );
    end

    tok_flags_t end_flags;
    assign end_flags = flags_chain[MAX_TERMINALS];

    // Neighbour memory: cell id and quality per slot.
    logic [MW-1:0]  mem [0:(2**AW)-1];
    logic [MW-1:0]  rd_data_reg;
    logic [NCW-1:0] iss_reg;
    logic           rd_v_reg;
    logic [NIW-1:0] rd_slot_reg;
    logic           mwr_en;
    logic [NIW-1:0] mwr_slot;
    logic           issue;

    assign issue = (state_reg == S_NBR) && (iss_reg < NBR_CNT);

    always_ff @(posedge clk)
    begin
        if (mwr_en)
        begin
            mem[{tsel_reg, mwr_slot}] <= {cell_reg, q_reg};
        end
        rd_data_reg <= mem[{tsel_reg, iss_reg[NIW-1:0]}];
        rd_slot_reg <= iss_reg[NIW-1:0];
    end

    // Scan state over the neighbour list.
    logic              best_found_reg, best_found_next;
    logic [Q_W-1:0]    best_q_reg, best_q_next;
    logic [CELL_W-1:0] best_c_reg, best_c_next;
    logic              m_hit_reg, m_hit_next;
    logic [NIW-1:0]    m_slot_reg, m_slot_next;
    logic              f_hit_reg, f_hit_next;
    logic [NIW-1:0]    f_slot_reg, f_slot_next;
    logic [CELL_W-1:0] rd_c;
    logic [Q_W-1:0]    rd_q;
    logic              rd_ok;
    logic              scan_done;
    logic [Q_W:0]      need_q;

    assign rd_c      = rd_data_reg[MW-1:Q_W];
    assign rd_q      = rd_data_reg[Q_W-1:0];
    assign rd_ok     = nmask_reg[rd_slot_reg];
    assign scan_done = (state_reg == S_NBR) && rd_v_reg && (rd_slot_reg == LAST_SLOT);
    assign need_q    = {1'b0, q_reg} + {1'b0, off_reg};

    always_comb
    begin
        best_found_next = best_found_reg;
        best_q_next     = best_q_reg;
        best_c_next     = best_c_reg;
        m_hit_next      = m_hit_reg;
        m_slot_next     = m_slot_reg;
        f_hit_next      = f_hit_reg;
        f_slot_next     = f_slot_reg;
        if (rd_v_reg)
        begin
            // Best neighbour: highest quality, ties to the lowest cell id.
            if (rd_ok && (rd_c != '0) && (rd_q != '0) &&
                (!best_found_reg || (rd_q > best_q_reg) ||
                 ((rd_q == best_q_reg) && (rd_c < best_c_reg))))
            begin
                best_found_next = 1'b1;
                best_q_next     = rd_q;
                best_c_next     = rd_c;
            end
            // Matching entry and first free slot for an update.
            if (rd_ok && (rd_c == cell_reg) && !m_hit_reg)
            begin
                m_hit_next  = 1'b1;
                m_slot_next = rd_slot_reg;
            end
            if (!rd_ok && !f_hit_reg)
            begin
                f_hit_next  = 1'b1;
                f_slot_next = rd_slot_reg;
            end
        end
    end

    // Table writes at the end of an update scan.
    always_comb
    begin
        mwr_en   = 1'b0;
        twr_en   = 1'b0;
        mwr_slot = m_slot_next;
        new_mask = nmask_reg;
        if (scan_done && !is_a2_reg)
        begin
            if (m_hit_next)
            begin
                mwr_en = 1'b1;
            end
            else if (f_hit_next)
            begin
                mwr_en   = 1'b1;
                twr_en   = 1'b1;
                mwr_slot = f_slot_next;
                new_mask[f_slot_next] = 1'b1;
            end
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_ch.report_id == a2_id_reg)
                    begin
                        state_next = (in_ch.quality > thr_reg) ? S_FIN : S_TERM;
                    end
                    else if (in_ch.report_id == a4_id_reg)
                    begin
                        state_next = in_ch.neighbour_present ? S_TERM : S_FIN;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_TERM:
            begin
                if (end_flags.valid)
                begin
                    if (end_flags.hit || (!is_a2_reg && end_flags.free_found))
                    begin
                        state_next = S_NBR;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_NBR:
            begin
                if (scan_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_ch.valid || out_ch.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            start_reg <= 1'b0;
            rd_v_reg  <= 1'b0;
            iss_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= accept && (state_next == S_TERM);
            rd_v_reg  <= issue;
            if (state_reg != S_NBR)
            begin
                iss_reg <= '0;
            end
            else if (issue)
            begin
                iss_reg <= iss_reg + 1'b1;
            end
        end
    end

    // Item fields, scan registers and the pending result.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rnti_reg  <= in_ch.terminal;
            cell_reg  <= in_ch.neighbour_cell;
            q_reg     <= in_ch.quality;
            is_a2_reg <= (in_ch.report_id == a2_id_reg);
            res_target_reg <= '0;
            if (in_ch.report_id == a2_id_reg)
            begin
                res_status_reg <= ST_INVALID_A2;
            end
            else if (in_ch.report_id == a4_id_reg)
            begin
                res_status_reg <= ST_EMPTY_A4;
            end
            else
            begin
                res_status_reg <= ST_UNKNOWN_ID;
            end
        end
        if ((state_reg == S_TERM) && end_flags.valid)
        begin
            best_found_reg <= 1'b0;
            best_q_reg     <= '0;
            best_c_reg     <= '0;
            m_hit_reg      <= 1'b0;
            m_slot_reg     <= '0;
            f_hit_reg      <= 1'b0;
            f_slot_reg     <= '0;
            if (end_flags.hit)
            begin
                tsel_reg  <= hidx_chain[MAX_TERMINALS];
                nmask_reg <= mask_chain[MAX_TERMINALS];
            end
            else
            begin
                tsel_reg  <= fidx_chain[MAX_TERMINALS];
                nmask_reg <= '0;
            end
            if (is_a2_reg && !end_flags.hit)
            begin
                res_status_reg <= ST_UNKNOWN_TERMINAL;
            end
            else if (!is_a2_reg && !end_flags.hit && !end_flags.free_found)
            begin
                res_status_reg <= ST_FULL;
            end
        end
        if (state_reg == S_NBR)
        begin
            best_found_reg <= best_found_next;
            best_q_reg     <= best_q_next;
            best_c_reg     <= best_c_next;
            m_hit_reg      <= m_hit_next;
            m_slot_reg     <= m_slot_next;
            f_hit_reg      <= f_hit_next;
            f_slot_reg     <= f_slot_next;
        end
        if (scan_done)
        begin
            if (is_a2_reg)
            begin
                if (best_found_next && ({1'b0, best_q_next} >= need_q))
                begin
                    res_status_reg <= ST_HANDOVER;
                    res_target_reg <= best_c_next;
                end
                else
                begin
                    res_status_reg <= ST_NO_HANDOVER;
                end
            end
            else
            begin
                res_status_reg <= (m_hit_next || f_hit_next) ? ST_UPDATED : ST_FULL;
            end
        end
    end

    // Output register.
    logic              out_valid_reg;
    logic [2:0]        out_status_reg;
    logic [CELL_W-1:0] out_target_reg;
    logic              load_out;

    assign load_out = (state_reg == S_FIN) && (!out_valid_reg || out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_target_reg <= res_target_reg;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.status      = out_status_reg;
    assign out_ch.handover    = (out_status_reg == ST_HANDOVER);
    assign out_ch.target_cell = out_target_reg;

endmodule

[tb/sv/rsrq_a2_a4_handover_decision_checker.sv]
module rsrq_a2_a4_handover_decision_checker
    import rahd_pkg::*;
#(
    parameter int MAX_TERMINALS  = 16,
    parameter int MAX_NEIGHBOURS = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    rahd_in_if.sink    in_ch,
    rahd_out_if.sink   out_ch,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output int         failures,
    output int         pending,
    output int         handovers,
    output int         fulls
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]        status;
        logic              handover;
        logic [CELL_W-1:0] target_cell;
    } decision_t;

    localparam int SLOTS = MAX_TERMINALS * MAX_NEIGHBOURS;

    logic [ID_W-1:0] a2_id, a4_id;
    logic [Q_W-1:0]  threshold, offset;
    logic              term_used [MAX_TERMINALS];
    logic [RNTI_W-1:0] term_rnti [MAX_TERMINALS];
    logic              nbr_used  [SLOTS];
    logic [CELL_W-1:0] nbr_cell  [SLOTS];
    logic [Q_W-1:0]    nbr_q     [SLOTS];
    decision_t expected_decisions[$];

    function automatic int lookup_terminal(logic [RNTI_W-1:0] rnti);
        for (int t = 0; t < MAX_TERMINALS; t++)
            if (term_used[t] && term_rnti[t] == rnti)
                return t;
        return -1;
    endfunction

    // Store or refresh one neighbour measurement.
    function automatic logic [2:0] store_neighbour(logic [RNTI_W-1:0] rnti,
                                                   logic [CELL_W-1:0] cell_id,
                                                   logic [Q_W-1:0] q);
        int t;
        int free_slot;
        t = lookup_terminal(rnti);
        free_slot = -1;
        if (t < 0)
        begin
            for (int n = 0; n < MAX_TERMINALS; n++)
                if (!term_used[n] && t < 0)
                    t = n;
            if (t < 0)
                return ST_FULL;
            term_used[t] = 1'b1;
            term_rnti[t] = rnti;
            for (int n = 0; n < MAX_NEIGHBOURS; n++)
                nbr_used[t * MAX_NEIGHBOURS + n] = 1'b0;
        end
        for (int n = 0; n < MAX_NEIGHBOURS; n++)
        begin
            int s;
            s = t * MAX_NEIGHBOURS + n;
            if (nbr_used[s])
            begin
                if (nbr_cell[s] == cell_id)
                begin
                    nbr_q[s] = q;
                    return ST_UPDATED;
                end
            end
            else if (free_slot < 0)
                free_slot = s;
        end
        if (free_slot < 0)
            return ST_FULL;
        nbr_used[free_slot] = 1'b1;
        nbr_cell[free_slot] = cell_id;
        nbr_q[free_slot] = q;
        return ST_UPDATED;
    endfunction

    // Compute the decision caused by one report.
    function automatic decision_t decide(logic [ID_W-1:0] id, logic [RNTI_W-1:0] rnti,
                                         logic present, logic [CELL_W-1:0] cell_id,
                                         logic [Q_W-1:0] q);
        decision_t d;
        int t;
        logic found;
        logic [CELL_W-1:0] best_cell;
        logic [Q_W-1:0] best_q;
        d = '0;
        found = 1'b0;
        best_cell = '0;
        best_q = '0;
        if (id == a2_id)
        begin
            t = lookup_terminal(rnti);
            if (q > threshold)
                d.status = ST_INVALID_A2;
            else if (t < 0)
                d.status = ST_UNKNOWN_TERMINAL;
            else
            begin
                for (int n = 0; n < MAX_NEIGHBOURS; n++)
                begin
                    int s;
                    s = t * MAX_NEIGHBOURS + n;
                    if (nbr_used[s] && nbr_cell[s] != 0 && nbr_q[s] != 0 &&
                        (!found || nbr_q[s] > best_q ||
                         (nbr_q[s] == best_q && nbr_cell[s] < best_cell)))
                    begin
                        found = 1'b1;
                        best_cell = nbr_cell[s];
                        best_q = nbr_q[s];
                    end
                end
                if (found && int'(best_q) - int'(q) >= int'(offset))
                begin
                    d.status = ST_HANDOVER;
                    d.handover = 1'b1;
                    d.target_cell = best_cell;
                end
                else
                    d.status = ST_NO_HANDOVER;
            end
        end
        else if (id == a4_id)
            d.status = present ? store_neighbour(rnti, cell_id, q) : ST_EMPTY_A4;
        else
            d.status = ST_UNKNOWN_ID;
        return d;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a2_id = A2_ID_RST;
            a4_id = A4_ID_RST;
            threshold = THRESHOLD_RST;
            offset = OFFSET_RST;
            for (int t = 0; t < MAX_TERMINALS; t++)
                term_used[t] = 1'b0;
            for (int s = 0; s < SLOTS; s++)
                nbr_used[s] = 1'b0;
            expected_decisions.delete();
            failures = 0;
            pending = 0;
            handovers = 0;
            fulls = 0;
        end
        else
        begin
            decision_t got, want;
            // Check the result first; one item is in work at a time.
            if (out_ch.valid && out_ch.ready)
            begin
                got = {out_ch.status, out_ch.handover, out_ch.target_cell};
                if (expected_decisions.size() == 0)
                begin
                    $error("unexpected result status=%0d", got.status);
                    failures++;
                end
                else
                begin
                    want = expected_decisions.pop_front();
                    if (got.status != want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        failures++;
                    end
                    if (got.handover != want.handover)
                    begin
                        $error("handover: expected %0d, got %0d",
                               want.handover, got.handover);
                        failures++;
                    end
                    if (got.target_cell != want.target_cell)
                    begin
                        $error("target_cell: expected %0d, got %0d",
                               want.target_cell, got.target_cell);
                        failures++;
                    end
                    if (want.status == ST_HANDOVER)
                        handovers++;
                    if (want.status == ST_FULL)
                        fulls++;
                end
            end
            if (in_ch.valid && in_ch.ready)
                expected_decisions.push_back(decide(in_ch.report_id, in_ch.terminal,
                    in_ch.neighbour_present, in_ch.neighbour_cell, in_ch.quality));
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_A2_ID:     a2_id = cfg_data;
                    CFG_A4_ID:     a4_id = cfg_data;
                    CFG_THRESHOLD: threshold = cfg_data[Q_W-1:0];
                    CFG_OFFSET:    offset = cfg_data[Q_W-1:0];
                    default: ;
                endcase
            end
            pending = expected_decisions.size();
        end
    end
endmodule

[tb/sv/rsrq_a2_a4_handover_decision_test.sv]
module rsrq_a2_a4_handover_decision_test;
    import rahd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = CFG_A2_ID;
    logic [7:0] cfg_data = '0;
    int failures, pending, handovers, fulls;
    int cycles = 0;
    int sent = 0;
    int ready_hold = 0;
    logic [ID_W-1:0] cur_a2 = A2_ID_RST, cur_a4 = A4_ID_RST;

    rahd_in_if  in_ch ();
    rahd_out_if out_ch ();

    rsrq_a2_a4_handover_decision dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .out_ch(out_ch), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data));

    rsrq_a2_a4_handover_decision_checker checker_i (.clk(clk), .rst_n(rst_n),
        .in_ch(in_ch), .out_ch(out_ch), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .failures(failures), .pending(pending),
        .handovers(handovers), .fulls(fulls));

    always #2 clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 1000000)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.report_id = '0;
        in_ch.terminal = '0;
        in_ch.neighbour_present = 1'b0;
        in_ch.neighbour_cell = '0;
        in_ch.quality = '0;
        out_ch.ready = 1'b0;
    end

    // The result side idles at random: mostly short gaps, now and then a long one.
    always @(negedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold--;
            out_ch.ready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 10)
        begin
            ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                     : $urandom_range(0, 2);
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    // Offer one item and hold it until accepted, with an optional random gap first.
    task automatic send(logic [7:0] id, logic [15:0] rnti, logic present,
                        logic [15:0] cell_id, logic [5:0] q);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        repeat (gap) @(negedge clk);
        in_ch.valid = 1'b1;
        in_ch.report_id = id;
        in_ch.terminal = rnti;
        in_ch.neighbour_present = present;
        in_ch.neighbour_cell = cell_id;
        in_ch.quality = q;
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
        in_ch.valid = 1'b0;
        sent++;
    endtask

    task automatic drain();
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] value);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_A2_ID)
            cur_a2 = value;
        if (idx == CFG_A4_ID)
            cur_a4 = value;
    endtask

    // Pick an id: mostly A2/A4, sometimes anything.
    function automatic logic [7:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return cur_a4;
        if (r < 85)
            return cur_a2;
        return 8'($urandom());
    endfunction

    initial
    begin
        logic [15:0] pool [24];
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: extremes, each status and the corner cases.
        send(A2_ID_RST, 16'd5, 1'b0, 16'd0, 6'd10);        // unknown terminal
        send(A4_ID_RST, 16'd5, 1'b0, 16'd9, 6'd10);        // empty A4
        send(8'd0, 16'd5, 1'b1, 16'd9, 6'd10);             // unknown id
        send(8'hFF, 16'hFFFF, 1'b1, 16'hFFFF, 6'h3F);      // unknown id
        send(A4_ID_RST, 16'd5, 1'b1, 16'd0, 6'd34);        // cell 0 never a candidate
        send(A4_ID_RST, 16'd5, 1'b1, 16'd7, 6'd0);         // RSRQ 0 never a candidate
        send(A2_ID_RST, 16'd5, 1'b0, 16'd0, 6'd0);         // no candidate
        send(A4_ID_RST, 16'd5, 1'b1, 16'hFFFF, 6'd20);
        send(A4_ID_RST, 16'd5, 1'b1, 16'd300, 6'd20);      // tie goes to lower cell
        send(A2_ID_RST, 16'd5, 1'b0, 16'd0, 6'd19);        // handover to 300
        send(A2_ID_RST, 16'd5, 1'b0, 16'd0, 6'd20);        // margin too small
        send(A2_ID_RST, 16'd5, 1'b0, 16'd0, 6'd31);        // invalid A2
        send(A4_ID_RST, 16'd5, 1'b1, 16'd300, 6'h3F);      // update, quality beyond range
        for (int c = 1; c <= 6; c++)
            send(A4_ID_RST, 16'd5, 1'b1, 16'(1000 + c), 6'd5); // fill list, last two full
        send(A2_ID_RST, 16'd5, 1'b0, 16'd0, 6'd30);
        for (int t = 0; t < 17; t++)
            send(A4_ID_RST, 16'(100 + t), 1'b1, 16'd44, 6'd12); // terminal table full
        drain();

        // Random phases over several settings.
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: begin write_reg(CFG_OFFSET, 8'd0); write_reg(CFG_THRESHOLD, 8'd34); end
                1: begin write_reg(CFG_A2_ID, 8'hFF); write_reg(CFG_A4_ID, 8'h00);
                         write_reg(CFG_OFFSET, 8'd34); end
                2: begin write_reg(CFG_A2_ID, 8'h5A); write_reg(CFG_A4_ID, 8'h5A);
                         write_reg(CFG_THRESHOLD, 8'd0); write_reg(CFG_OFFSET, 8'd3); end
                3: begin write_reg(CFG_A4_ID, 8'hA5); write_reg(CFG_THRESHOLD, 8'h3F);
                         write_reg(CFG_OFFSET, 8'h3F); end
                4: begin write_reg(CFG_A2_ID, 8'd1); write_reg(CFG_A4_ID, 8'd2);
                         write_reg(CFG_THRESHOLD, 8'd30); write_reg(CFG_OFFSET, 8'd1); end
                default: begin write_reg(CFG_OFFSET, 8'd0); write_reg(CFG_THRESHOLD, 8'd20); end
            endcase
            for (int i = 0; i < 24; i++)
                pool[i] = (i == 23) ? 16'(65535 - phase) : 16'($urandom());
            for (int i = 0; i < 200; i++)
            begin
                logic [5:0] q;
                q = ($urandom_range(0, 19) == 0) ? 6'($urandom()) : 6'($urandom_range(0, 34));
                send(pick_id(), pool[$urandom_range(0, 23)], $urandom_range(0, 9) != 0,
                     ($urandom_range(0, 9) == 0) ? 16'($urandom()) :
                                                   16'($urandom_range(0, 11)), q);
            end
            drain();
        end

        $display("Sent %0d report items over seven register settings.", sent);
        $display("Saw %0d handovers and %0d full-table results.", handovers, fulls);
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

[sim.f]
src/rahd_pkg.sv
src/rahd_if.sv
src/rahd_term_cell.sv
src/rsrq_a2_a4_handover_decision.sv
tb/sv/rsrq_a2_a4_handover_decision_checker.sv
tb/sv/rsrq_a2_a4_handover_decision_test.sv
